>>> hdl/jvsw_pkg.sv
`default_nettype none

package jvsw_pkg;

  localparam int JOINTS          = 7;
  localparam int VEL_WIDTH       = 16;
  localparam int COEF_WIDTH      = 16;
  localparam int LIMIT_WIDTH     = 15;
  localparam int TIMER_WIDTH     = 24;
  localparam int PERIOD_WIDTH    = 16;
  localparam int CFG_DATA_WIDTH  = 24;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET   = LIMIT_WIDTH'(819);
  localparam logic [COEF_WIDTH-1:0]  SMOOTH_RESET  = COEF_WIDTH'(64881);
  localparam logic [COEF_WIDTH-1:0]  DECAY_RESET   = COEF_WIDTH'(52429);
  localparam logic [TIMER_WIDTH-1:0] TIMEOUT_RESET = TIMER_WIDTH'(200000);

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_VEL_LIMIT = 2'd0,
    REG_SMOOTH    = 2'd1,
    REG_DECAY     = 2'd2,
    REG_TIMEOUT   = 2'd3
  } cfg_reg_t;

  typedef logic signed [VEL_WIDTH-1:0] vel_t;

  typedef struct packed {
    logic                    kind;
    logic [PERIOD_WIDTH-1:0] tick_period_us;
    vel_t                    vel_0;
    vel_t                    vel_1;
    vel_t                    vel_2;
    vel_t                    vel_3;
    vel_t                    vel_4;
    vel_t                    vel_5;
    vel_t                    vel_6;
  } in_item_t;

  typedef struct packed {
    vel_t cmd_0;
    vel_t cmd_1;
    vel_t cmd_2;
    vel_t cmd_3;
    vel_t cmd_4;
    vel_t cmd_5;
    vel_t cmd_6;
    logic stale;
  } out_item_t;

  // Per-transaction strobes shared by every lane
  typedef struct packed {
    logic load;
    logic step;
    logic stale;
  } lane_ctrl_t;

  typedef struct packed {
    logic                   stale;
    logic [TIMER_WIDTH-1:0] timer;
  } wd_status_t;

endpackage

`default_nettype wire

>>> hdl/jvsw_watchdog.sv
`default_nettype none

module jvsw_watchdog
  import jvsw_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    load,
  input  wire logic                    step,
  input  wire logic [PERIOD_WIDTH-1:0] period,
  input  wire logic [TIMER_WIDTH-1:0]  timeout,
  output wd_status_t                   status
);

  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic                   seen_r, seen_nxt;
  logic [TIMER_WIDTH:0]   sum;

  always_comb begin
    sum       = {1'b0, timer_r} + (TIMER_WIDTH + 1)'(period);
    timer_nxt = timer_r;
    seen_nxt  = seen_r;
    if (load) begin
      seen_nxt = 1'b1;
    end else if (step) begin
      seen_nxt = 1'b0;
      if (seen_r) begin
        timer_nxt = '0;
      end else if (sum[TIMER_WIDTH]) begin
        timer_nxt = '1;  // saturate, never wrap
      end else begin
        timer_nxt = sum[TIMER_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      seen_r  <= 1'b0;
    end else begin
      timer_r <= timer_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // Stale decision for the tick being taken this cycle
  assign status.stale = timer_nxt > timeout;
  assign status.timer = timer_r;

endmodule

`default_nettype wire

>>> hdl/jvsw_lane.sv
`default_nettype none

module jvsw_lane
  import jvsw_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lane_ctrl_t             ctrl,
  input  wire vel_t                   vel_in,
  input  wire logic [LIMIT_WIDTH-1:0] vel_limit,
  input  wire logic [COEF_WIDTH-1:0]  smooth_coef,
  input  wire logic [COEF_WIDTH-1:0]  decay_coef,
  output vel_t                        smoothed
);

  localparam int DIFF_W = VEL_WIDTH + 1;
  localparam int PROD_W = DIFF_W + COEF_WIDTH + 1;
  localparam int SUM_W  = PROD_W - COEF_WIDTH + 1;

  vel_t target_r, target_nxt;
  vel_t smooth_r, smooth_nxt;
  vel_t lim_pos, lim_neg;

  logic signed [DIFF_W-1:0]     diff;
  logic signed [COEF_WIDTH:0]   coef;
  logic signed [PROD_W-1:0]     prod;
  logic signed [SUM_W-1:0]      base;
  logic signed [SUM_W-1:0]      acc;

  // Clamp to +/- limit; the limit is narrower than the velocity, so it always fits
  assign lim_pos = VEL_WIDTH'({1'b0, vel_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    target_nxt = target_r;
    if (ctrl.load) begin
      if (vel_in < lim_neg) begin
        target_nxt = lim_neg;
      end else if (vel_in > lim_pos) begin
        target_nxt = lim_pos;
      end else begin
        target_nxt = vel_in;
      end
    end
  end

  // a*s + (1-a)*t == t + a*(s - t); decay is d*s with zero base.
  // The base has zero fraction bits, so flooring the product alone is exact.
  always_comb begin
    if (ctrl.stale) begin
      coef = $signed({1'b0, decay_coef});
      diff = DIFF_W'(smooth_r);
      base = '0;
    end else begin
      coef = $signed({1'b0, smooth_coef});
      diff = DIFF_W'(smooth_r) - DIFF_W'(target_r);
      base = SUM_W'(target_r);
    end
    prod = PROD_W'(diff) * PROD_W'(coef);
    acc  = base + SUM_W'(prod >>> COEF_WIDTH);
    smooth_nxt = ctrl.step ? acc[VEL_WIDTH-1:0] : smooth_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      smooth_r <= '0;
    end else begin
      target_r <= target_nxt;
      smooth_r <= smooth_nxt;
    end
  end

  assign smoothed = smooth_nxt;

endmodule

`default_nettype wire

>>> hdl/joint_velocity_smoother_watchdog_unit.sv
`default_nettype none

// Joint velocity smoother with command watchdog. A command transaction
// (kind 0) clamps seven joint velocities to +/- velocity_limit and stores them
// as targets; it produces no result. A tick transaction (kind 1) advances the
// silence timer by tick_period_us (or clears it if a command arrived since the
// previous tick) and produces one result: while the timer is at or below
// timeout_us each joint moves toward its target through a first-order
// low-pass, s' = floor((a*s + (1-a)*t) / 2^16); once past it each joint is
// scaled by the decay factor and stale is set. Velocities are Q3.12, the
// coefficients Q0.16. One transaction is accepted every clock cycle while
// in_stall is low: each of the seven lanes holds one 17x17 multiply-add that
// updates its state in the cycle of acceptance, and the results sit in one
// output register. in_stall rises only while a result waits in that register
// and out_stall is high. Configuration is written through cfg_we/cfg_index/
// cfg_wdata and must only change while no result is pending.

module joint_velocity_smoother_watchdog_unit
  import jvsw_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire in_item_t                   in_data,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output out_item_t                       out_data,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  logic [LIMIT_WIDTH-1:0] limit_r;
  logic [COEF_WIDTH-1:0]  smooth_coef_r;
  logic [COEF_WIDTH-1:0]  decay_coef_r;
  logic [TIMER_WIDTH-1:0] timeout_r;

  logic       in_acc, cmd_acc, tick_acc;
  lane_ctrl_t lane_ctrl;
  wd_status_t wd_status;

  vel_t vel_in   [JOINTS];
  vel_t smoothed [JOINTS];

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // Configuration registers; unknown indexes cannot occur at this width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= LIMIT_RESET;
      smooth_coef_r <= SMOOTH_RESET;
      decay_coef_r  <= DECAY_RESET;
      timeout_r     <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VEL_LIMIT: limit_r       <= cfg_wdata[LIMIT_WIDTH-1:0];
        REG_SMOOTH:    smooth_coef_r <= cfg_wdata[COEF_WIDTH-1:0];
        REG_DECAY:     decay_coef_r  <= cfg_wdata[COEF_WIDTH-1:0];
        REG_TIMEOUT:   timeout_r     <= cfg_wdata[TIMER_WIDTH-1:0];
      endcase
    end
  end

  // Hold the input only while a finished result is still waiting downstream
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign cmd_acc  = in_acc && (in_data.kind == KIND_CMD);
  assign tick_acc = in_acc && (in_data.kind == KIND_TICK);

  jvsw_watchdog u_watchdog (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (cmd_acc),
    .step    (tick_acc),
    .period  (in_data.tick_period_us),
    .timeout (timeout_r),
    .status  (wd_status)
  );

  assign lane_ctrl.load  = cmd_acc;
  assign lane_ctrl.step  = tick_acc;
  assign lane_ctrl.stale = wd_status.stale;

  assign vel_in[0] = in_data.vel_0;
  assign vel_in[1] = in_data.vel_1;
  assign vel_in[2] = in_data.vel_2;
  assign vel_in[3] = in_data.vel_3;
  assign vel_in[4] = in_data.vel_4;
  assign vel_in[5] = in_data.vel_5;
  assign vel_in[6] = in_data.vel_6;

  // One filter lane per joint, all running in the same cycle
  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    jvsw_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (lane_ctrl),
      .vel_in      (vel_in[j]),
      .vel_limit   (limit_r),
      .smooth_coef (smooth_coef_r),
      .decay_coef  (decay_coef_r),
      .smoothed    (smoothed[j])
    );
  end

  // Merge the lanes into the output register; advance on every tick, drop the
  // valid once the consumer has taken the transaction
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tick_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      out_data_r.cmd_0 <= smoothed[0];
      out_data_r.cmd_1 <= smoothed[1];
      out_data_r.cmd_2 <= smoothed[2];
      out_data_r.cmd_3 <= smoothed[3];
      out_data_r.cmd_4 <= smoothed[4];
      out_data_r.cmd_5 <= smoothed[5];
      out_data_r.cmd_6 <= smoothed[6];
      out_data_r.stale <= wd_status.stale;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A tick always lands a result in the output register
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> out_valid_r)
    else $error("tick transaction produced no result");

  // A command into an empty output register produces nothing
  a_cmd_silent: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_acc && !out_valid_r |=> !out_valid_r)
    else $error("command transaction produced a result");

  // The pending stale flag agrees with the watchdog timer that produced it
  a_stale_matches_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.stale == (wd_status.timer > timeout_r)))
    else $error("stale flag disagrees with silence timer");

endmodule

`default_nettype wire

>>> bench/joint_velocity_smoother_watchdog_unit_tb.sv
`timescale 1ns / 1ps

module joint_velocity_smoother_watchdog_unit_tb;
  import jvsw_pkg::*;

  // Cycles with no transaction on either channel before the run is abandoned.
  // The sender gaps and receiver stalls are both drawn by pick_gap.
  localparam int unsigned IDLE_LIMIT = 2000;
  // Cycles to let pass after the last result before touching the registers.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam longint TIMER_TOP = (longint'(1) << TIMER_WIDTH) - 1;
  localparam longint COEF_ONE = longint'(1) << COEF_WIDTH;

  // Track the smoother state and hold the smoothed commands still owed by the
  // block, oldest first.
  class joint_cmd_scoreboard;
    longint limit_q;
    longint smooth_q;
    longint decay_q;
    longint timeout_q;
    longint target_q [JOINTS];
    longint smoothed_q [JOINTS];
    longint silence_us;
    bit heard;
    out_item_t owed_cmds [$];
    int unsigned mismatches;
    int unsigned commands;
    int unsigned ticks;
    int unsigned decayed;
    int unsigned checked;

    function new();
      limit_q = LIMIT_RESET;
      smooth_q = SMOOTH_RESET;
      decay_q = DECAY_RESET;
      timeout_q = TIMEOUT_RESET;
      foreach (target_q[j]) begin
        target_q[j] = 0;
        smoothed_q[j] = 0;
      end
      silence_us = 0;
      heard = 1'b0;
      mismatches = 0;
      commands = 0;
      ticks = 0;
      decayed = 0;
      checked = 0;
    endfunction

    function vel_t vel_in(in_item_t it, int j);
      case (j)
        0: return it.vel_0;
        1: return it.vel_1;
        2: return it.vel_2;
        3: return it.vel_3;
        4: return it.vel_4;
        5: return it.vel_5;
        default: return it.vel_6;
      endcase
    endfunction

    function vel_t cmd_out(out_item_t o, int j);
      case (j)
        0: return o.cmd_0;
        1: return o.cmd_1;
        2: return o.cmd_2;
        3: return o.cmd_3;
        4: return o.cmd_4;
        5: return o.cmd_5;
        default: return o.cmd_6;
      endcase
    endfunction

    function out_item_t with_cmd(out_item_t o, int j, vel_t v);
      case (j)
        0: o.cmd_0 = v;
        1: o.cmd_1 = v;
        2: o.cmd_2 = v;
        3: o.cmd_3 = v;
        4: o.cmd_4 = v;
        5: o.cmd_5 = v;
        default: o.cmd_6 = v;
      endcase
      return o;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] val);
      case (idx)
        REG_VEL_LIMIT: limit_q = val[LIMIT_WIDTH-1:0];
        REG_SMOOTH:    smooth_q = val[COEF_WIDTH-1:0];
        REG_DECAY:     decay_q = val[COEF_WIDTH-1:0];
        REG_TIMEOUT:   timeout_q = val[TIMER_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // Advance the state by one accepted input; a tick owes one result.
    function void note_item(in_item_t it);
      longint v;
      longint acc;
      out_item_t want;
      bit decay_now;
      if (it.kind == KIND_CMD) begin
        for (int j = 0; j < JOINTS; j++) begin
          v = vel_in(it, j);
          if (v > limit_q) v = limit_q;
          if (v < -limit_q) v = -limit_q;
          target_q[j] = v;
        end
        heard = 1'b1;
        commands++;
        return;
      end
      if (heard) begin
        silence_us = 0;
        heard = 1'b0;
      end else begin
        silence_us = silence_us + it.tick_period_us;
        if (silence_us > TIMER_TOP) silence_us = TIMER_TOP;
      end
      decay_now = silence_us > timeout_q;
      want = '0;
      for (int j = 0; j < JOINTS; j++) begin
        if (decay_now)
          acc = decay_q * smoothed_q[j];
        else
          acc = smooth_q * smoothed_q[j] + (COEF_ONE - smooth_q) * target_q[j];
        smoothed_q[j] = acc >>> COEF_WIDTH;
        want = with_cmd(want, j, vel_t'(smoothed_q[j]));
      end
      want.stale = decay_now;
      ticks++;
      if (decay_now) decayed++;
      owed_cmds.push_back(want);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: mismatch on %s in result %0d: got %0d, wanted %0d",
                 $time, what, checked, got, want);
    endtask

    task check_cmd(out_item_t got);
      out_item_t want;
      if (owed_cmds.size() == 0) begin
        report_mismatch("result with none outstanding", 0, 0);
        return;
      end
      want = owed_cmds.pop_front();
      for (int j = 0; j < JOINTS; j++)
        if (cmd_out(got, j) !== cmd_out(want, j))
          report_mismatch($sformatf("cmd_%0d", j), cmd_out(got, j), cmd_out(want, j));
      if (got.stale !== want.stale) report_mismatch("stale", got.stale, want.stale);
      checked++;
    endtask

    function int unsigned owed();
      return owed_cmds.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_VEL_LIMIT;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

  joint_cmd_scoreboard sb;
  bit calm = 1'b0;            // while set, neither side idles
  int unsigned quiet_cycles = 0;
  int unsigned settings = 0;

  joint_velocity_smoother_watchdog_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Velocity biased towards the clamp boundary, the extremes and small values.
  function automatic vel_t pick_vel();
    int lim;
    int unsigned r;
    lim = int'(sb.limit_q);
    r = $urandom_range(99, 0);
    if (r < 40) return vel_t'($urandom);
    if (r < 70) return vel_t'(int'($urandom_range(2 * lim + 6, 0)) - (lim + 3));
    if (r < 80) begin
      case ($urandom_range(4, 0))
        0: return vel_t'(32767);
        1: return vel_t'(-32768);
        2: return vel_t'(1);
        3: return vel_t'(-1);
        default: return vel_t'(0);
      endcase
    end
    return vel_t'(int'($urandom_range(511, 0)) - 256);
  endfunction

  function automatic int unsigned pick_period(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 5) return 0;
    if (r < 10) return 65535;
    if (r < 20) return $urandom_range(65535, 0);
    return $urandom_range(hi, lo);
  endfunction

  function automatic in_item_t command_of(int v0, int v1, int v2, int v3, int v4,
                                          int v5, int v6, int period);
    in_item_t it;
    it.kind = KIND_CMD;
    it.tick_period_us = PERIOD_WIDTH'(period);
    it.vel_0 = vel_t'(v0);
    it.vel_1 = vel_t'(v1);
    it.vel_2 = vel_t'(v2);
    it.vel_3 = vel_t'(v3);
    it.vel_4 = vel_t'(v4);
    it.vel_5 = vel_t'(v5);
    it.vel_6 = vel_t'(v6);
    return it;
  endfunction

  // Ticks carry random velocities, which the block must ignore.
  function automatic in_item_t tick_of(int period);
    in_item_t it;
    it = command_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, period);
    it.kind = KIND_TICK;
    return it;
  endfunction

  function automatic in_item_t random_command();
    return command_of(pick_vel(), pick_vel(), pick_vel(), pick_vel(), pick_vel(),
                      pick_vel(), pick_vel(), $urandom_range(65535, 0));
  endfunction

  // Offer one transaction after a random gap and hold it until it is taken.
  // Return at the accepting edge without touching in_valid, so that a
  // following transaction can keep it high.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, let an edge pass so that the final acceptance is noted, wait
  // for every owed result, then give the block SETTLE_CYCLES of quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold the write enable high across consecutive writes; program_regs drops it.
  task automatic put_reg(cfg_reg_t idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_WIDTH'(val);
    sb.write_reg(idx, CFG_DATA_WIDTH'(val));
    @(posedge clk);
  endtask

  task automatic program_regs(int unsigned lim, int unsigned smooth, int unsigned decay,
                              int unsigned timeout);
    put_reg(REG_VEL_LIMIT, lim);
    put_reg(REG_SMOOTH, smooth);
    put_reg(REG_DECAY, decay);
    put_reg(REG_TIMEOUT, timeout);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Hand-picked sequences: clamp edges, several commands per tick, the timer
  // landing exactly on the timeout, and the coefficient extremes.
  task automatic run_directed();
    send_item(tick_of(0));
    send_item(command_of(32767, -32768, 819, -819, 820, -820, 0, 65535));
    send_item(command_of(100, -100, 818, -821, 0, 1, -1, 0));
    send_item(tick_of(65535));
    repeat (3) send_item(tick_of(65535));
    send_item(tick_of(3395));              // timer now equals the timeout
    send_item(tick_of(1));                 // one past it: decay
    send_item(tick_of(0));
    send_item(command_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 4660));
    send_item(tick_of(0));
    wait_idle();
    // Full-range clamp, output jumps straight to target, decay uses the largest factor.
    program_regs(32767, 0, 65535, 0);
    send_item(command_of(32767, -32768, -1, 1, 0, 12345, -12345, 0));
    send_item(tick_of(0));
    send_item(tick_of(1));
    send_item(tick_of(65535));
    wait_idle();
    // Zero clamp, heaviest smoothing, and a timeout that can never be passed.
    program_regs(0, 65535, 0, TIMER_TOP);
    send_item(command_of(32767, -32768, 5, -5, 1, -1, 0, 65535));
    send_item(tick_of(65535));
    send_item(tick_of(65535));
    wait_idle();
    // Decay by zero wipes the outputs at once.
    program_regs(0, 65535, 0, 10);
    send_item(tick_of(11));
    send_item(tick_of(0));
  endtask

  // Random traffic: tick streams with commands mixed in, plus bursts of
  // silence long enough to trip the watchdog. Some stretches run flat out.
  task automatic run_traffic(int unsigned items, int unsigned cmd_pct, int unsigned hi,
                             int unsigned lo);
    int unsigned silent;
    in_item_t it;
    silent = 0;
    for (int unsigned n = 0; n < items; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(3, 0) == 0);
      if (silent != 0) begin
        silent--;
        it = tick_of(pick_period(lo, hi));
      end else if ($urandom_range(99, 0) < cmd_pct) begin
        it = random_command();
      end else begin
        it = tick_of(pick_period(lo, hi));
        if ($urandom_range(99, 0) < 4) silent = $urandom_range(80, 5);
      end
      send_item(it);
    end
    calm = 1'b0;
  endtask

  // Sample both channels at the edge; a transaction moves when valid is high
  // and stall is low.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_cmd(out_data);
    end
  end

  // Receiver back-pressure: random stalls, released for a few cycles between.
  initial begin
    int unsigned hold;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  end

  // Abandon the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d cycles without a transaction", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Start from the reset register values.
    run_directed();

    wait_idle();
    program_regs(32767, 0, 0, 0);
    run_traffic(195, 30, 50, 0);

    wait_idle();
    program_regs(0, 65535, 65535, 1000);
    run_traffic(195, 25, 300, 0);

    wait_idle();
    program_regs(LIMIT_RESET, SMOOTH_RESET, DECAY_RESET, TIMEOUT_RESET);
    run_traffic(195, 15, 5000, 0);

    wait_idle();
    program_regs($urandom_range(32767, 0), $urandom_range(65535, 0),
                 $urandom_range(65535, 0), $urandom_range(20000, 0));
    run_traffic(195, 20, 2000, 0);

    wait_idle();
    program_regs($urandom_range(32767, 30000), $urandom_range(65535, 0),
                 $urandom_range(65535, 0), $urandom_range(TIMER_TOP, 0));
    run_traffic(195, 20, 65535, 0);

    wait_idle();
    program_regs(1, 32768, 32768, 5);
    run_traffic(195, 35, 8, 0);

    // Long silences with large periods drive the timer into saturation:
    // first with a timeout that can never be passed, then one just below.
    wait_idle();
    program_regs($urandom_range(32767, 0), $urandom_range(65535, 0),
                 $urandom_range(65535, 0), TIMER_TOP);
    run_traffic(380, 0, 65535, 60000);

    wait_idle();
    program_regs($urandom_range(32767, 0), $urandom_range(65535, 0),
                 $urandom_range(65535, 0), TIMER_TOP - 1);
    run_traffic(380, 0, 65535, 60000);

    wait_idle();
    $display("Covered %0d command and %0d tick transactions over %0d register settings.",
             sb.commands, sb.ticks, settings);
    $display("%0d results took the decay path; %0d field mismatches.",
             sb.decayed, sb.mismatches);
    if (sb.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
